### hdl/htd_pkg.sv
package htd_pkg;

    localparam int IDX_W          = 9;
    localparam int SYM_W          = 8;
    localparam int BYTE_W         = 8;
    localparam int NODE_COUNT_DEF = 512;

    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [SYM_W-1:0] sym;
    } node_entry_t;

endpackage

### hdl/htd_node_ram.sv
module htd_node_ram
    import htd_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  node_entry_t       wr_entry,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_idx,
    output node_entry_t       rd_entry
);

    localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    node_entry_t mem [NODE_COUNT];
    node_entry_t rd_data_reg;
    logic        rd_oob_reg;
    logic        wr_in_range;
    logic        rd_in_range;

    assign wr_in_range = (32'(wr_idx) < NODE_COUNT);
    assign rd_in_range = (32'(rd_idx) < NODE_COUNT);

    always_ff @(posedge aclk) begin
        if (wr_en && wr_in_range) begin
            mem[ADDR_W'(wr_idx)] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[ADDR_W'(rd_idx)];
            rd_oob_reg  <= !rd_in_range;
        end
    end

    // an index past the table reads as an internal node with both children zero
    assign rd_entry = rd_oob_reg ? node_entry_t'('0) : rd_data_reg;

endmodule

### hdl/huffman_tree_decoder_unit.sv
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   mode, node_index, left/right_child,
//                                          is_leaf, leaf_symbol, packed_byte
// m_        out        m_valid / m_ready   symbol, last_of_byte
// cfg_      in         cfg_wr_en           cfg_wr_data (root_node)
//
// A load request is taken while idle and leaves s_ready high. A decode request holds
// s_ready low through one root read, eight bit steps and the release of the last
// symbol of the byte; a byte that yields no symbol skips the release.
// The walk is paced by the single read port of the node table: each bit's child
// read depends on the entry returned by the read before it.
// A held result on m_ stalls a bit step that must hand over a symbol, and the release.
// aresetn is synchronous, active low; it clears control state, not the node table.
module huffman_tree_decoder_unit
    import htd_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_mode,
    input  logic [IDX_W-1:0]  s_node_index,
    input  logic [IDX_W-1:0]  s_left_child,
    input  logic [IDX_W-1:0]  s_right_child,
    input  logic              s_is_leaf,
    input  logic [SYM_W-1:0]  s_leaf_symbol,
    input  logic [BYTE_W-1:0] s_packed_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SYM_W-1:0]  m_symbol,
    output logic              m_last_of_byte
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROOT  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    localparam int CNT_W = $clog2(BYTE_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BYTE_W - 1);

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  root_node_reg;
    logic              at_root_reg, at_root_next;
    node_entry_t       root_entry_reg, root_entry_next;
    node_entry_t       cur_entry_reg, cur_entry_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0]  pend_sym_reg, pend_sym_next;
    logic              out_valid_reg;
    logic [SYM_W-1:0]  out_sym_reg;
    logic              out_last_reg;

    logic              accept;
    logic              out_free;
    logic              stall;
    logic              push;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    node_entry_t       rd_entry;
    node_entry_t       wr_entry;
    node_entry_t       cur;
    logic [IDX_W-1:0]  child_idx;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    assign m_valid        = out_valid_reg;
    assign m_symbol       = out_sym_reg;
    assign m_last_of_byte = out_last_reg;

    assign wr_entry = '{left: s_left_child, right: s_right_child,
                        leaf: s_is_leaf, sym: s_leaf_symbol};

    htd_node_ram #(
        .NODE_COUNT (NODE_COUNT)
    ) u_node_ram (
        .aclk     (aclk),
        .wr_en    (accept && !s_mode),
        .wr_idx   (s_node_index),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry)
    );

    // node the next bit starts from
    always_comb begin
        if (state_reg == ST_ROOT) begin
            cur = at_root_reg ? rd_entry : cur_entry_reg;
        end else begin
            cur = rd_entry.leaf ? root_entry_reg : rd_entry;
        end
    end

    assign child_idx = byte_reg[BYTE_W-1] ? cur.right : cur.left;

    assign stall = (state_reg == ST_WALK) && rd_entry.leaf && pend_valid_reg && !out_free;
    assign push  = ((state_reg == ST_WALK) && !stall && rd_entry.leaf && pend_valid_reg)
                || ((state_reg == ST_FLUSH) && out_free);

    always_comb begin
        state_next      = state_reg;
        at_root_next    = at_root_reg;
        root_entry_next = root_entry_reg;
        cur_entry_next  = cur_entry_reg;
        byte_next       = byte_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        rd_en           = 1'b0;
        rd_idx          = child_idx;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_mode) begin
                        rd_en      = 1'b1;
                        rd_idx     = root_node_reg;
                        byte_next  = s_packed_byte;
                        state_next = ST_ROOT;
                    end else begin
                        at_root_next = 1'b1;
                    end
                end
            end
            ST_ROOT: begin
                root_entry_next = rd_entry;
                rd_en           = 1'b1;
                byte_next       = {byte_reg[BYTE_W-2:0], 1'b0};
                cnt_next        = '0;
                state_next      = ST_WALK;
            end
            ST_WALK: begin
                if (!stall) begin
                    if (rd_entry.leaf) begin
                        at_root_next    = 1'b1;
                        pend_valid_next = 1'b1;
                        pend_sym_next   = rd_entry.sym;
                    end else begin
                        at_root_next   = 1'b0;
                        cur_entry_next = rd_entry;
                    end
                    if (cnt_reg == LAST_BIT) begin
                        state_next = (rd_entry.leaf || pend_valid_reg) ? ST_FLUSH : ST_IDLE;
                    end else begin
                        rd_en     = 1'b1;
                        byte_next = {byte_reg[BYTE_W-2:0], 1'b0};
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            root_node_reg  <= '0;
            at_root_reg    <= 1'b1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            at_root_reg    <= at_root_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_wr_en) begin
                root_node_reg <= cfg_wr_data;
            end
            if (push) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        root_entry_reg <= root_entry_next;
        cur_entry_reg  <= cur_entry_next;
        byte_reg       <= byte_next;
        cnt_reg        <= cnt_next;
        pend_sym_reg   <= pend_sym_next;
        if (push) begin
            out_sym_reg  <= pend_sym_reg;
            out_last_reg <= (state_reg == ST_FLUSH);
        end
    end

`ifndef SYNTH
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending symbol left over while idle");

    a_root_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROOT) |-> $past(accept && s_mode))
        else $error("root read without a decode request");

    a_flush_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH && out_free) |=> (m_valid && m_last_of_byte && !pend_valid_reg))
        else $error("end of byte did not release last symbol");

    a_leaf_push_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && rd_entry.leaf && pend_valid_reg && out_free)
        |=> (m_valid && !m_last_of_byte))
        else $error("earlier symbol of byte not handed over");
`endif

endmodule
